/* rtl/bfgb_pkg.sv */
// Package: item types, controller states, command/status groups and the glyph table.
`default_nettype none

package bfgb_pkg;

   // First and last character codes that have a glyph.
   localparam logic [7:0] GLYPH_FIRST = 8'd48;
   localparam logic [7:0] GLYPH_LAST  = 8'd90;

   // Pen offset applied at a string start, and the advance per character.
   localparam logic [15:0] PEN_OFFSET  = 16'd4;
   localparam logic [15:0] PEN_ADVANCE = 16'd8;

   typedef struct packed {
      logic [7:0]  char_code;
      logic        start_of_string;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [7:0]  pixel_color;
   } req_type;

   typedef struct packed {
      logic [16:0] pixel_address;
      logic [7:0]  pixel_value;
      logic        last_pixel;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic scan;
      logic flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic draw;
      logic scan_end;
      logic flush_done;
   } dp_status_type;

   // One 8x8 glyph per entry: row 0 in the top byte, and within a row the
   // most significant bit is the leftmost column.
   function automatic logic [63:0] glyph_bits(input logic [5:0] idx);
      logic [63:0] g;
      case (idx)
         6'd0:  g = 64'h708898A8_C8887000;
         6'd1:  g = 64'h40C04040_4040E000;
         6'd2:  g = 64'h70880810_2040F800;
         6'd3:  g = 64'h70880810_08887000;
         6'd4:  g = 64'h08182848_FC080800;
         6'd5:  g = 64'hF88080F0_08887000;
         6'd6:  g = 64'h204080F0_88887000;
         6'd7:  g = 64'hF8081020_40404000;
         6'd8:  g = 64'h70888870_88887000;
         6'd9:  g = 64'h70888878_08087000;
         6'd10: g = 64'h00006060_00606000;
         6'd11: g = 64'h00006060_00606020;
         6'd12: g = 64'h10204080_40201000;
         6'd13: g = 64'h0000F800_F8000000;
         6'd14: g = 64'h80402010_20408000;
         6'd15: g = 64'h78840408_10001000;
         6'd16: g = 64'h708888A8_B8807800;
         6'd17: g = 64'h20508888_F8888800;
         6'd18: g = 64'hF08888F0_8888F000;
         6'd19: g = 64'h70888080_80887000;
         6'd20: g = 64'hF0888888_8888F000;
         6'd21: g = 64'hF88080E0_8080F800;
         6'd22: g = 64'hF88080E0_80808000;
         6'd23: g = 64'h70888080_98887800;
         6'd24: g = 64'h888888F8_88888800;
         6'd25: g = 64'hE0404040_4040E000;
         6'd26: g = 64'h38101010_10906000;
         6'd27: g = 64'h8890A0C0_A0908800;
         6'd28: g = 64'h80808080_8080F800;
         6'd29: g = 64'h82C6AA92_82828200;
         6'd30: g = 64'h84C4A494_8C848400;
         6'd31: g = 64'h70888888_88887000;
         6'd32: g = 64'hF08888F0_80808000;
         6'd33: g = 64'h70888888_A8906800;
         6'd34: g = 64'hF08888F0_A0908800;
         6'd35: g = 64'h70888070_08887000;
         6'd36: g = 64'hF8202020_20202000;
         6'd37: g = 64'h88888888_88887000;
         6'd38: g = 64'h88888850_50202000;
         6'd39: g = 64'h82828282_92926C00;
         6'd40: g = 64'h88885020_50888800;
         6'd41: g = 64'h88888850_20202000;
         6'd42: g = 64'hF8081020_4080F800;
         default: g = 64'h0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* rtl/bfgb_ctrl.sv */
// Controller state machine that sequences accept, row-base setup, glyph scan and flush.
`default_nettype none

module bfgb_ctrl import bfgb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.draw) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.flush_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/bfgb_datapath.sv */
// Datapath: pen state, glyph shift register, pixel address unit, pending and output registers.
`default_nettype none

module bfgb_datapath import bfgb_pkg::*; #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   input  wire req_type      req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_item
);

   localparam logic [16:0] WIDTH_L  = 17'(SCREEN_WIDTH);
   localparam logic [16:0] HEIGHT_L = 17'(SCREEN_HEIGHT);

   // Pen state kept across items.
   logic [15:0] pen_col_ff, pen_col_in;
   logic [15:0] pen_row_ff, pen_row_in;
   logic        supp_ff, supp_in;
   logic [7:0]  color_ff, color_in;

   // Per-item scan registers.
   logic [15:0] scan_col_ff, scan_col_in;
   logic [15:0] scan_row_ff, scan_row_in;
   logic [16:0] row_base_ff, row_base_in;
   logic [63:0] glyph_ff, glyph_in;
   logic [5:0]  cnt_ff, cnt_in;

   // One pixel is held back so that the last write of a character can be marked.
   logic [16:0] pend_addr_ff, pend_addr_in;
   logic        pend_valid_ff, pend_valid_in;

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_item_ff, out_item_in;

   logic [15:0] eff_col;
   logic [15:0] eff_row;
   logic        eff_supp;
   logic        in_font;
   logic [5:0]  glyph_idx;
   logic [16:0] col;
   logic [16:0] row;
   logic [16:0] addr;
   logic        hit;
   logic        out_free;
   logic        stall;
   logic        step;
   logic        flush_go;
   logic        out_load_mid;
   logic        out_load_last;

   always_comb begin
      eff_col   = req_item.start_of_string ? req_item.origin_x + PEN_OFFSET : pen_col_ff;
      eff_row   = req_item.start_of_string ? req_item.origin_y + PEN_OFFSET : pen_row_ff;
      eff_supp  = req_item.start_of_string ? ({1'b0, eff_col} > WIDTH_L) : supp_ff;
      in_font   = (req_item.char_code >= GLYPH_FIRST) && (req_item.char_code <= GLYPH_LAST);
      glyph_idx = 6'(req_item.char_code - GLYPH_FIRST);

      col  = {1'b0, scan_col_ff} + 17'(cnt_ff[2:0]);
      row  = {1'b0, scan_row_ff} + 17'(cnt_ff[5:3]);
      addr = row_base_ff + col;
      hit  = cmd.scan && glyph_ff[63] && (col < WIDTH_L) && (row < HEIGHT_L);

      out_free      = !out_valid_ff || rsp_ready;
      stall         = hit && pend_valid_ff && !out_free;
      step          = cmd.scan && !stall;
      flush_go      = cmd.flush && (!pend_valid_ff || out_free);
      out_load_mid  = step && hit && pend_valid_ff;
      out_load_last = flush_go && pend_valid_ff;

      status.draw       = !eff_supp && in_font;
      status.scan_end   = step && (&cnt_ff);
      status.flush_done = flush_go;
   end

   always_comb begin
      pen_col_in    = pen_col_ff;
      pen_row_in    = pen_row_ff;
      supp_in       = supp_ff;
      color_in      = color_ff;
      scan_col_in   = scan_col_ff;
      scan_row_in   = scan_row_ff;
      row_base_in   = row_base_ff;
      glyph_in      = glyph_ff;
      cnt_in        = cnt_ff;
      pend_addr_in  = pend_addr_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;

      if (cmd.accept) begin
         pen_col_in  = eff_col + PEN_ADVANCE;
         pen_row_in  = eff_row;
         supp_in     = eff_supp;
         color_in    = req_item.start_of_string ? req_item.pixel_color : color_ff;
         scan_col_in = eff_col;
         scan_row_in = eff_row;
         glyph_in    = glyph_bits(glyph_idx);
         cnt_in      = '0;
      end

      if (cmd.prep) begin
         row_base_in = 17'(32'(scan_row_ff) * 32'(SCREEN_WIDTH));
      end

      if (step) begin
         glyph_in = {glyph_ff[62:0], 1'b0};
         cnt_in   = cnt_ff + 6'd1;
         if (&cnt_ff[2:0]) begin
            row_base_in = row_base_ff + WIDTH_L;
         end
         if (hit) begin
            pend_addr_in  = addr;
            pend_valid_in = 1'b1;
         end
      end

      if (flush_go) begin
         pend_valid_in = 1'b0;
      end

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load_mid || out_load_last) begin
         out_valid_in              = 1'b1;
         out_item_in.pixel_address = pend_addr_ff;
         out_item_in.pixel_value   = color_ff;
         out_item_in.last_pixel    = out_load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_col_ff    <= '0;
         pen_row_ff    <= '0;
         supp_ff       <= 1'b0;
         color_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pen_col_ff    <= pen_col_in;
         pen_row_ff    <= pen_row_in;
         supp_ff       <= supp_in;
         color_ff      <= color_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_col_ff  <= scan_col_in;
      scan_row_ff  <= scan_row_in;
      row_base_ff  <= row_base_in;
      glyph_ff     <= glyph_in;
      cnt_ff       <= cnt_in;
      pend_addr_ff <= pend_addr_in;
      out_item_ff  <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // Every character advances the pen by one cell, drawn or not.
   a_pen_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> pen_col_ff == $past(eff_col) + PEN_ADVANCE)
      else $error("pen column did not advance by one cell");

   // The held-back pixel of the previous character is gone before a new one starts.
   a_pend_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !pend_valid_ff)
      else $error("pending pixel left over at item accept");

   // A blocked scan step must not move the bit counter.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> cnt_ff == $past(cnt_ff))
      else $error("scan advanced while stalled");

   // The last-write flag comes only from the flush step.
   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      out_load_mid |-> !cmd.flush)
      else $error("mid-glyph write during flush");

endmodule

`default_nettype wire

/* rtl/bitmap_font_glyph_blitter_top.sv */
// Top level of the 8x8 bitmap font glyph blitter: controller plus datapath.
`default_nettype none

// Usage: each req_ item is one character with a start-of-string flag, origin and
// color. A string start places the pen at the origin plus 4 in both axes and
// latches the color; a string whose pen column then lies beyond the screen width
// is suppressed. Codes 48 to 90 draw an 8x8 glyph; all other codes draw nothing.
// The pen column advances by 8 after every character.
// Each set, on-screen glyph bit yields one rsp_ item carrying a framebuffer
// address (column plus row times SCREEN_WIDTH), the color, and a flag on the
// final write of the character. Items leave rows top to bottom, columns left to
// right.
// Sequence: a character without a glyph, or in a suppressed string, is only
// accepted. A drawn character is accepted, then the row base is multiplied out,
// then the glyph bits are walked one per cycle unless the receiver stalls, and
// then the held-back last write is flushed. The single glyph shift register and
// the one-pixel look-ahead register set this rate. The output register lets the
// next character start while a write still waits to be taken.
// When the receiver stalls, the walk pauses on the next visible bit; nothing is
// dropped. Reset (synchronous, active high) returns the pen to (0,0), the color
// to 0, clears suppression and empties the output.
module bitmap_font_glyph_blitter_top import bfgb_pkg::*; #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_item
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller only sequences; all arithmetic and storage sit in the datapath.
   bfgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bfgb_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the glyph blitter: directed and random character strings against a predictor.
`timescale 1ns / 100ps

module tb;
   import bfgb_pkg::*;

   localparam int SCREEN_W     = 320;
   localparam int SCREEN_H     = 240;
   localparam int ITEM_TARGET  = 420;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int IDLE_PERCENT = 13;
   // The receiver stops taking writes for a long stretch starting at this cycle.
   localparam int HOLD_START   = 1500;
   localparam int HOLD_CYCLES  = 500;
   // Neither side idles while the cycle count lies in this window.
   localparam int QUIET_FIRST  = 4000;
   localparam int QUIET_LAST   = 10000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   bitmap_font_glyph_blitter_top #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The font, one glyph per word for codes 48 to 90. Each byte is a row, top row
   // in the most significant byte, and the leftmost column is the top bit of a row.
   logic [63:0] font_glyphs [43] = '{
      64'h70_88_98_A8_C8_88_70_00, 64'h40_C0_40_40_40_40_E0_00,
      64'h70_88_08_10_20_40_F8_00, 64'h70_88_08_10_08_88_70_00,
      64'h08_18_28_48_FC_08_08_00, 64'hF8_80_80_F0_08_88_70_00,
      64'h20_40_80_F0_88_88_70_00, 64'hF8_08_10_20_40_40_40_00,
      64'h70_88_88_70_88_88_70_00, 64'h70_88_88_78_08_08_70_00,
      64'h00_00_60_60_00_60_60_00, 64'h00_00_60_60_00_60_60_20,
      64'h10_20_40_80_40_20_10_00, 64'h00_00_F8_00_F8_00_00_00,
      64'h80_40_20_10_20_40_80_00, 64'h78_84_04_08_10_00_10_00,
      64'h70_88_88_A8_B8_80_78_00, 64'h20_50_88_88_F8_88_88_00,
      64'hF0_88_88_F0_88_88_F0_00, 64'h70_88_80_80_80_88_70_00,
      64'hF0_88_88_88_88_88_F0_00, 64'hF8_80_80_E0_80_80_F8_00,
      64'hF8_80_80_E0_80_80_80_00, 64'h70_88_80_80_98_88_78_00,
      64'h88_88_88_F8_88_88_88_00, 64'hE0_40_40_40_40_40_E0_00,
      64'h38_10_10_10_10_90_60_00, 64'h88_90_A0_C0_A0_90_88_00,
      64'h80_80_80_80_80_80_F8_00, 64'h82_C6_AA_92_82_82_82_00,
      64'h84_C4_A4_94_8C_84_84_00, 64'h70_88_88_88_88_88_70_00,
      64'hF0_88_88_F0_80_80_80_00, 64'h70_88_88_88_A8_90_68_00,
      64'hF0_88_88_F0_A0_90_88_00, 64'h70_88_80_70_08_88_70_00,
      64'hF8_20_20_20_20_20_20_00, 64'h88_88_88_88_88_88_70_00,
      64'h88_88_88_50_50_20_20_00, 64'h82_82_82_82_92_92_6C_00,
      64'h88_88_50_20_50_88_88_00, 64'h88_88_88_50_20_20_20_00,
      64'hF8_08_10_20_40_80_F8_00
   };

   // Characters waiting to be offered, and framebuffer writes still owed by the block.
   req_type char_queue[$];
   rsp_type pixel_queue[$];

   // Predicted pen, color and suppression of the current string.
   logic [15:0] pen_x         = '0;
   logic [15:0] pen_y         = '0;
   logic [7:0]  ink           = '0;
   logic        string_hidden = 1'b0;

   int   cycle_count    = 0;
   int   mismatch_count = 0;
   int   hold_left      = 0;
   logic req_sent       = 1'b0;
   logic quiet;

   assign quiet = cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST;

   // Works out the writes that one accepted character causes and updates the pen.
   // A found pixel is held back one step so that the final one can carry the
   // last-write flag.
   task automatic draw_character(input req_type ch);
      logic [63:0] glyph;
      rsp_type     held;
      logic        have_held;
      int          col;
      int          row;
      have_held = 1'b0;
      held      = '0;
      if (ch.start_of_string) begin
         pen_x         = ch.origin_x + PEN_OFFSET;
         pen_y         = ch.origin_y + PEN_OFFSET;
         ink           = ch.pixel_color;
         string_hidden = pen_x > SCREEN_W;
      end
      if (!string_hidden && ch.char_code >= GLYPH_FIRST && ch.char_code <= GLYPH_LAST) begin
         glyph = font_glyphs[6'(ch.char_code - GLYPH_FIRST)];
         for (int r = 0; r < 8; r++) begin
            for (int k = 0; k < 8; k++) begin
               col = pen_x + k;
               row = pen_y + r;
               // Pixels that fall off the right or bottom of the frame are dropped.
               if (glyph[6'(63 - 8 * r - k)] && col < SCREEN_W && row < SCREEN_H) begin
                  if (have_held)
                     pixel_queue.push_back(held);
                  held.pixel_address = 17'(col + row * SCREEN_W);
                  held.pixel_value   = ink;
                  held.last_pixel    = 1'b0;
                  have_held          = 1'b1;
               end
            end
         end
         if (have_held) begin
            held.last_pixel = 1'b1;
            pixel_queue.push_back(held);
         end
      end
      // The pen advances even for blank or suppressed characters.
      pen_x = pen_x + PEN_ADVANCE;
   endtask

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", msg);
   endtask

   task automatic add_char(input logic [7:0] code, input logic sos, input logic [15:0] ox,
                           input logic [15:0] oy, input logic [7:0] color);
      req_type ch;
      ch.char_code       = code;
      ch.start_of_string = sos;
      ch.origin_x        = ox;
      ch.origin_y        = oy;
      ch.pixel_color     = color;
      char_queue.push_back(ch);
   endtask

   // Sender. A new item is picked only when nothing is on offer or the previous
   // item was just taken, so valid and the payload hold steady until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_sent) begin
         if (char_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_item  <= char_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. It counts its own long hold-off; during it the sender keeps
   // offering, so the block's output backs up and it stops taking characters.
   always @(negedge clock) begin
      if (cycle_count == HOLD_START)
         hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   // Both handshakes are observed at the rising edge. An accepted character feeds
   // the predictor, and an accepted write is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         req_sent <= req_valid && req_ready;
         if (req_valid && req_ready)
            draw_character(req_item);
         if (rsp_valid && rsp_ready) begin : check_write
            rsp_type want;
            if (pixel_queue.size() == 0) begin
               flag_error($sformatf("unexpected write: address %0d value %0d last %0d",
                                    rsp_item.pixel_address, rsp_item.pixel_value,
                                    rsp_item.last_pixel));
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_item.pixel_address !== want.pixel_address ||
                   rsp_item.pixel_value !== want.pixel_value ||
                   rsp_item.last_pixel !== want.last_pixel)
                  flag_error($sformatf({"write differs: expected address %0d value %0d ",
                                        "last %0d, got address %0d value %0d last %0d"},
                                       want.pixel_address, want.pixel_value,
                                       want.last_pixel, rsp_item.pixel_address,
                                       rsp_item.pixel_value, rsp_item.last_pixel));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_font_glyph_blitter_top: mismatch");
         $finish;
      end
   end

   initial begin
      int          string_len;
      int          pick;
      logic [15:0] ox;
      logic [15:0] oy;

      // A character before any string start uses the reset pen and color; its
      // origin fields are all ones but must be ignored.
      add_char(8'd65, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
      // A plain string at the top left, first and last glyph codes.
      add_char(8'd48, 1'b1, 16'd0, 16'd0, 8'hFF);
      add_char(8'd90, 1'b0, 16'd0, 16'd0, 8'd0);
      // Blank codes: zero, space, the neighbors of the glyph range and the top code.
      add_char(8'd0, 1'b0, 16'd0, 16'd0, 8'd0);
      add_char(8'd32, 1'b0, 16'd0, 16'd0, 8'd0);
      add_char(8'd47, 1'b0, 16'd0, 16'd0, 8'd0);
      add_char(8'd91, 1'b0, 16'd0, 16'd0, 8'd0);
      add_char(8'd255, 1'b0, 16'd0, 16'd0, 8'd0);
      // Near the right edge the glyph is clipped, then falls wholly off the frame.
      add_char(8'd77, 1'b1, 16'd312, 16'd100, 8'h5A);
      add_char(8'd87, 1'b0, 16'd0, 16'd0, 8'd0);
      // A pen column of exactly the screen width is not suppressed, one more is.
      add_char(8'd72, 1'b1, 16'd316, 16'd0, 8'h3C);
      add_char(8'd72, 1'b1, 16'd317, 16'd0, 8'h3C);
      add_char(8'd66, 1'b0, 16'd0, 16'd0, 8'd0);
      // The pen offset wraps around 16 bits, in both axes.
      add_char(8'd66, 1'b1, 16'hFFFC, 16'hFFFF, 8'h81);
      add_char(8'd56, 1'b1, 16'hFFFB, 16'd0, 8'h81);
      add_char(8'd56, 1'b0, 16'd0, 16'd0, 8'd0);
      // Clipping at the bottom edge, and a string wholly below the frame.
      add_char(8'd56, 1'b1, 16'hFFFF, 16'd232, 8'h42);
      add_char(8'd56, 1'b1, 16'd100, 16'd236, 8'h42);
      // The bottom row of the semicolon lands on the last framebuffer address.
      add_char(8'd59, 1'b1, 16'd313, 16'd228, 8'h00);
      add_char(8'd84, 1'b1, 16'd150, 16'd110, 8'hA5);
      add_char(8'd61, 1'b0, 16'd0, 16'd0, 8'd0);

      // Random strings: a start item with an origin mostly on screen, then a few
      // characters, mostly with glyphs. Origin fields of later items are noise.
      while (char_queue.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            ox = 16'($urandom_range(0, 330));
            oy = 16'($urandom_range(0, 250));
         end else if (pick < 85) begin
            ox = 16'($urandom);
            oy = 16'($urandom);
         end else begin
            ox = 16'($urandom_range(296, 330));
            oy = 16'($urandom_range(220, 250));
         end
         string_len = $urandom_range(1, 12);
         for (int i = 0; i < string_len; i++) begin
            pick = $urandom_range(0, 99);
            add_char(pick < 80 ? 8'($urandom_range(48, 90)) : 8'($urandom_range(0, 255)),
                     i == 0, i == 0 ? ox : 16'($urandom), i == 0 ? oy : 16'($urandom),
                     8'($urandom));
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every character to be taken, then for every owed write, then a
      // little longer to catch anything the block sends beyond the prediction.
      while (char_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (pixel_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pixel_queue.size() == 0)
         $display("bitmap_font_glyph_blitter_top: match");
      else
         $display("bitmap_font_glyph_blitter_top: mismatch");
      $finish;
   end

endmodule
